### src/pbf_pkg.sv
// Shared types and constants of the partitioned Bloom filter.
// Depends on nothing; every other file but pbf_ram imports it.
package pbf_pkg;

  localparam int DEF_BITMAP_BITS = 65536;
  localparam int DEF_MAX_HASHES  = 32;

  localparam int HASH_W  = 64;
  localparam int NUM_W   = 6;
  localparam int PART_W  = 17;
  localparam int COUNT_W = 32;
  localparam int BIDX_W  = NUM_W + PART_W + 1;

  localparam logic [HASH_W-1:0] BIG_PRIME = 64'hFFFF_FFFF_FFFF_FFC5;

  localparam logic [NUM_W-1:0]  RST_NUM_HASHES     = 6'd4;
  localparam logic [PART_W-1:0] RST_PARTITION_BITS = 17'd16384;

  localparam logic REG_NUM_HASHES     = 1'b0;
  localparam logic REG_PARTITION_BITS = 1'b1;

  localparam logic REQ_CONTAINS = 1'b0;
  localparam logic REQ_ADD      = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [HASH_W-1:0] hash_word0;
    logic [HASH_W-1:0] hash_word1;
    logic [HASH_W-1:0] hash_word2;
    logic [HASH_W-1:0] hash_word3;
  } req_t;

  typedef struct packed {
    logic               was_present;
    logic               was_added;
    logic [COUNT_W-1:0] item_count;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic prod_ld;
    logic hash_ld;
    logic div_start;
    logic idx_ld;
    logic mem_rd;
    logic mem_wr;
    logic clr_wr;
    logic probe_rst;
    logic probe_inc;
    logic miss;
    logic count_inc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic last_probe;
    logic bit_set;
    logic clear_done;
    logic is_add;
  } sts_t;

endpackage

### src/pbf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module pbf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/pbf_div.sv
// Bit-serial remainder unit: 64-bit dividend, one quotient bit per cycle.
// Depends on pbf_pkg.
module pbf_div
  import pbf_pkg::*;
#(
  parameter int DIV_W = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [HASH_W-1:0] dividend,
  input  logic [DIV_W-1:0]  divisor,
  output logic              busy,
  output logic [DIV_W-1:0]  rem
);

  localparam int CNT_W = $clog2(HASH_W + 1);

  logic [HASH_W-1:0] dvd;
  logic [DIV_W-1:0]  dsr;
  logic [CNT_W-1:0]  cnt;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;

  assign trial = {rem, dvd[HASH_W-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(HASH_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[HASH_W-2:0], 1'b0};
      rem <= (trial >= {1'b0, dsr}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end
  end

endmodule

### src/pbf_datapath.sv
// Datapath: request registers, probe hash, remainder unit, bitmap and count.
// Depends on pbf_pkg, pbf_div and pbf_ram.
module pbf_datapath
  import pbf_pkg::*;
#(
  parameter int BITMAP_BITS = DEF_BITMAP_BITS,
  parameter int MAX_HASHES  = DEF_MAX_HASHES
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  req_t              req,
  input  logic [NUM_W-1:0]  num_hashes,
  input  logic [PART_W-1:0] partition_bits,
  output rsp_t              rsp
);

  localparam int AW    = $clog2(BITMAP_BITS);
  localparam int RED_W = BIDX_W + 1;
  localparam logic [RED_W-1:0]  MAP_SIZE = RED_W'(BITMAP_BITS);
  localparam logic [BIDX_W-1:0] RECIP    = BIDX_W'((1 << BIDX_W) / BITMAP_BITS);

  req_t                 req_q;
  logic [NUM_W-1:0]     k_eff;
  logic [PART_W-1:0]    m_eff;
  logic [NUM_W-1:0]     probe;
  logic [HASH_W-1:0]    prod;
  logic [HASH_W-1:0]    prod_red;
  logic [HASH_W-1:0]    hash;
  logic [HASH_W-1:0]    base;
  logic [BIDX_W-1:0]    bidx;
  logic [BIDX_W-1:0]    part_base;
  logic                 present;
  logic                 added;
  logic [COUNT_W-1:0]   count;
  logic [AW-1:0]        clr_addr;
  logic [PART_W-1:0]    div_rem;
  logic [2*BIDX_W-1:0]  quo_prod;
  logic [BIDX_W-1:0]    quo;
  logic [RED_W-1:0]     quo_back;
  logic [RED_W-1:0]     rem_est;
  logic [RED_W-1:0]     wrapped;
  logic [AW-1:0]        baddr;
  logic [AW-1:0]        ram_waddr;
  logic                 ram_rdata;

  always_comb begin
    case (probe[1:0])
      2'd0:    base = req_q.hash_word0;
      2'd1:    base = req_q.hash_word1;
      2'd2:    base = req_q.hash_word2;
      default: base = req_q.hash_word3;
    endcase
  end

  assign prod_red  = (prod >= BIG_PRIME) ? prod - BIG_PRIME : prod;
  assign part_base = probe * m_eff;

  // Wrap the bit index to the bitmap size by reciprocal estimate and one correction.
  assign quo_prod = {{BIDX_W{1'b0}}, bidx} * {{BIDX_W{1'b0}}, RECIP};
  assign quo_back = RED_W'({1'b0, quo} * MAP_SIZE);
  assign wrapped  = (rem_est >= MAP_SIZE) ? rem_est - MAP_SIZE : rem_est;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
      if (num_hashes == '0) begin
        k_eff <= NUM_W'(1);
      end else if ({1'b0, num_hashes} > (NUM_W + 1)'(MAX_HASHES)) begin
        k_eff <= NUM_W'(MAX_HASHES);
      end else begin
        k_eff <= num_hashes;
      end
      m_eff <= (partition_bits == '0) ? PART_W'(1) : partition_bits;
    end
    if (cmd.prod_ld) begin
      prod <= HASH_W'(req_q.hash_word3 * probe);
    end
    if (cmd.hash_ld) begin
      hash <= (probe < NUM_W'(4)) ? base : req_q.hash_word1 + prod_red;
    end
    if (cmd.idx_ld) begin
      bidx <= part_base + BIDX_W'(div_rem);
    end
    quo     <= quo_prod[2*BIDX_W-1:BIDX_W];
    rem_est <= {1'b0, bidx} - quo_back;
    baddr   <= wrapped[AW-1:0];
    if (cmd.out_load) begin
      rsp.was_present <= present;
      rsp.was_added   <= added;
      rsp.item_count  <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe    <= '0;
      present  <= 1'b1;
      added    <= 1'b0;
      count    <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.load || cmd.probe_rst) begin
        probe <= '0;
      end else if (cmd.probe_inc) begin
        probe <= probe + 1'b1;
      end
      if (cmd.load) begin
        present <= 1'b1;
        added   <= 1'b0;
      end else begin
        if (cmd.miss) begin
          present <= 1'b0;
        end
        if (cmd.count_inc) begin
          added <= 1'b1;
        end
      end
      if (cmd.count_inc && count != '1) begin
        count <= count + 1'b1;
      end
      if (cmd.clr_wr) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  pbf_div #(
    .DIV_W(PART_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(hash),
    .divisor (m_eff),
    .busy    (sts.div_busy),
    .rem     (div_rem)
  );

  assign ram_waddr = cmd.clr_wr ? clr_addr : baddr;

  pbf_ram #(
    .WIDTH(1),
    .DEPTH(BITMAP_BITS)
  ) u_bitmap (
    .clk  (clk),
    .we   (cmd.mem_wr || cmd.clr_wr),
    .waddr(ram_waddr),
    .wdata(cmd.mem_wr),
    .re   (cmd.mem_rd),
    .raddr(baddr),
    .rdata(ram_rdata)
  );

  assign sts.last_probe = ({1'b0, probe} + 1'b1) == {1'b0, k_eff};
  assign sts.bit_set    = ram_rdata;
  assign sts.clear_done = clr_addr == AW'(BITMAP_BITS - 1);
  assign sts.is_add     = req_q.req_type == REQ_ADD;

endmodule

### src/pbf_ctrl.sv
// Controller: sequences clearing, probe lookup, bit setting and result handoff.
// Depends on pbf_pkg.
module pbf_ctrl
  import pbf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  output logic rsp_valid,
  input  logic rsp_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [12:0] {
    S_CLEAR  = 13'b0_0000_0000_0001,
    S_IDLE   = 13'b0_0000_0000_0010,
    S_PROD   = 13'b0_0000_0000_0100,
    S_HASH   = 13'b0_0000_0000_1000,
    S_START1 = 13'b0_0000_0001_0000,
    S_DIV1   = 13'b0_0000_0010_0000,
    S_BIDX   = 13'b0_0000_0100_0000,
    S_QUOT   = 13'b0_0000_1000_0000,
    S_REM    = 13'b0_0001_0000_0000,
    S_WRAP   = 13'b0_0010_0000_0000,
    S_ACCESS = 13'b0_0100_0000_0000,
    S_CHECK  = 13'b0_1000_0000_0000,
    S_FINISH = 13'b1_0000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   set_phase;
  logic   set_phase_next;
  logic   rsp_valid_next;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    set_phase_next = set_phase;
    req_ready      = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load       = 1'b1;
          set_phase_next = 1'b0;
          state_next     = S_PROD;
        end
      end
      S_PROD: begin
        cmd.prod_ld = 1'b1;
        state_next  = S_HASH;
      end
      S_HASH: begin
        cmd.hash_ld = 1'b1;
        state_next  = S_START1;
      end
      S_START1: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV1;
      end
      S_DIV1: begin
        if (!sts.div_busy) begin
          state_next = S_BIDX;
        end
      end
      S_BIDX: begin
        cmd.idx_ld = 1'b1;
        state_next = S_QUOT;
      end
      S_QUOT: begin
        state_next = S_REM;
      end
      S_REM: begin
        state_next = S_WRAP;
      end
      S_WRAP: begin
        state_next = S_ACCESS;
      end
      S_ACCESS: begin
        if (set_phase) begin
          cmd.mem_wr = 1'b1;
          if (sts.last_probe) begin
            cmd.count_inc = 1'b1;
            state_next    = S_FINISH;
          end else begin
            cmd.probe_inc = 1'b1;
            state_next    = S_PROD;
          end
        end else begin
          cmd.mem_rd = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.bit_set) begin
          cmd.miss = 1'b1;
          if (sts.is_add) begin
            cmd.probe_rst  = 1'b1;
            set_phase_next = 1'b1;
            state_next     = S_PROD;
          end else begin
            state_next = S_FINISH;
          end
        end else if (sts.last_probe) begin
          state_next = S_FINISH;
        end else begin
          cmd.probe_inc = 1'b1;
          state_next    = S_PROD;
        end
      end
      S_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.out_load) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      set_phase <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      set_phase <= set_phase_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

### src/partitioned_bloom_filter.sv
// Partitioned Bloom filter top level: APB registers, controller, datapath.
// A request tests its probes in turn and, on an add that finds a clear bit, then sets
// every probe from the first; each probe waits on the 64-step remainder unit.
// One request at a time: the next is taken only once the previous one is finished,
// later while a finished response stalls. Reset clears the bitmap one bit per cycle,
// and req_ready stays low until that pass is done; registers are writable throughout.
module partitioned_bloom_filter
  import pbf_pkg::*;
#(
  parameter int BITMAP_BITS = DEF_BITMAP_BITS,
  parameter int MAX_HASHES  = DEF_MAX_HASHES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [NUM_W-1:0]  num_hashes;
  logic [PART_W-1:0] partition_bits;
  cmd_t              cmd;
  sts_t              sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_hashes     <= RST_NUM_HASHES;
      partition_bits <= RST_PARTITION_BITS;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_NUM_HASHES:     num_hashes     <= pwdata[NUM_W-1:0];
        REG_PARTITION_BITS: partition_bits <= pwdata[PART_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_NUM_HASHES:     prdata = 32'(num_hashes);
      REG_PARTITION_BITS: prdata = 32'(partition_bits);
      default:            prdata = '0;
    endcase
  end

  pbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pbf_datapath #(
    .BITMAP_BITS(BITMAP_BITS),
    .MAX_HASHES (MAX_HASHES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .req           (req),
    .num_hashes    (num_hashes),
    .partition_bits(partition_bits),
    .rsp           (rsp)
  );

endmodule

### src/pbf_checker.sv
// Port-level checks of the partitioned Bloom filter, bound to the top level.
// Depends on pbf_pkg and partitioned_bloom_filter.
module pbf_checker
  import pbf_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_added_absent: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.was_present && rsp.was_added))
    else $error("key reported both present and added");

  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !req_ready)
    else $error("request taken during clearing pass");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while one is in work");

endmodule

bind partitioned_bloom_filter pbf_checker u_pbf_checker (.*);
